// ===== rtl/core/battery_status_frame_decoder_defines.svh =====
// assertion macros for the battery status frame decoder
// no dependencies; expects clock and reset in the scope of each use
`ifndef BATTERY_STATUS_FRAME_DECODER_DEFINES_SVH
`define BATTERY_STATUS_FRAME_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// plain property checked at every clock edge outside reset
`define BSFD_ASSERT(name, expr) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("bsfd assertion failed");

// implication checked in the same cycle
`define BSFD_ASSERT_IMPLY(name, cond, expr) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("bsfd implication failed");

`else

`define BSFD_ASSERT(name, expr)
`define BSFD_ASSERT_IMPLY(name, cond, expr)

`endif

`endif

// ===== rtl/core/bsfd_pkg.sv =====
// shared types, constants and the crc-16 step for the frame decoder
// no dependencies
`default_nettype none

package bsfd_pkg;

   // frame geometry
   localparam int IDX_W = 6;
   localparam logic [IDX_W-1:0] LAST_IDX_STATUS   = 6'd34;
   localparam logic [IDX_W-1:0] LAST_IDX_CAPACITY = 6'd12;
   localparam logic [IDX_W-1:0] IDLE_COUNT        = 6'd63;

   // capture offsets in the frame
   localparam logic [IDX_W-1:0] OFS_MODE  = 6'd3;
   localparam logic [IDX_W-1:0] OFS_VOLT  = 6'd5;
   localparam logic [IDX_W-1:0] OFS_AMP   = 6'd9;
   localparam logic [IDX_W-1:0] OFS_TEMP  = 6'd17;
   localparam logic [IDX_W-1:0] OFS_FAULT = 6'd25;
   localparam logic [IDX_W-1:0] OFS_LEVEL = 6'd3;
   localparam logic [IDX_W-1:0] OFS_CAP   = 6'd7;

   // crc-16 modbus
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // field decode constants
   localparam logic [31:0] OVERHEAT_MASK = 32'h0000_0018;
   localparam logic [16:0] TEMP_OFFSET   = 17'd40;
   localparam logic [15:0] MODE_CHARGING    = 16'd1;
   localparam logic [15:0] MODE_DISCHARGING = 16'd2;

   localparam logic [1:0] HEALTH_GOOD     = 2'd0;
   localparam logic [1:0] HEALTH_FAILURE  = 2'd1;
   localparam logic [1:0] HEALTH_OVERHEAT = 2'd2;

   localparam logic [1:0] CHG_CHARGING    = 2'd0;
   localparam logic [1:0] CHG_DISCHARGING = 2'd1;
   localparam logic [1:0] CHG_OTHER       = 2'd2;

   // byte operation codes
   localparam logic [1:0] OP_DATA    = 2'd0;
   localparam logic [1:0] OP_CRC_LOW = 2'd1;
   localparam logic [1:0] OP_FINAL   = 2'd2;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_BLOCK_KIND = 1'b0;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int RSP_DATA_W = 168;

   // classified byte handed from front to back
   typedef struct packed {
      logic [7:0]       rx_byte;
      logic [IDX_W-1:0] idx;
      logic             cap_kind;
      logic [1:0]       op;
   } bsfd_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } bsfd_queue_stat_type;

   typedef struct packed {
      logic pop;
      logic final_pop;
   } bsfd_back_stat_type;

   typedef struct packed {
      logic               crc_ok;
      logic [31:0]        voltage_mv;
      logic signed [31:0] current_ma;
      logic signed [16:0] temperature_c;
      logic [31:0]        protect_flags;
      logic [1:0]         health;
      logic [1:0]         charge_status;
      logic [15:0]        soc_centi_percent;
      logic [31:0]        capacity_mah;
   } bsfd_result_type;

   // one byte through the reflected crc, eight shift steps
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bsfd_front.sv =====
// front end: accepts bytes, tracks the frame position and classifies each word
// depends on bsfd_pkg
`default_nettype none

module bsfd_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         block_kind,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [7:0]                   req_tdata,   // [7:0] rx_byte
   input  wire logic                         req_tuser,   // [0] first_byte
   input  wire bsfd_pkg::bsfd_queue_stat_type q_stat,
   output logic                              q_push,
   output bsfd_pkg::bsfd_entry_type          q_entry
);
   import bsfd_pkg::*;

   logic [IDX_W-1:0] count_ff;
   logic [IDX_W-1:0] count_in;
   logic [IDX_W-1:0] idx;
   logic [IDX_W-1:0] last_idx;
   logic             live;
   logic             accept;
   logic [1:0]       op;

   assign req_tready = !q_stat.full;
   assign accept     = req_tvalid && req_tready;

   // position of this word and what the back end must do with it
   always_comb begin
      idx      = req_tuser ? '0 : count_ff;
      last_idx = block_kind ? LAST_IDX_CAPACITY : LAST_IDX_STATUS;
      live     = (idx <= last_idx);
      if (idx == last_idx) begin
         op = OP_FINAL;
      end else if (idx == last_idx - 6'd1) begin
         op = OP_CRC_LOW;
      end else begin
         op = OP_DATA;
      end
   end

   assign q_push           = accept && live;
   assign q_entry.rx_byte  = req_tdata;
   assign q_entry.idx      = idx;
   assign q_entry.cap_kind = block_kind;
   assign q_entry.op       = op;

   // frame position, parked at the idle count after the final word
   always_comb begin
      count_in = count_ff;
      if (q_push) begin
         count_in = (op == OP_FINAL) ? IDLE_COUNT : idx + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/bsfd_queue.sv =====
// short register queue of classified words between front and back
// depends on bsfd_pkg
`default_nettype none

module bsfd_queue #(
   parameter int DEPTH = bsfd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   input  wire bsfd_pkg::bsfd_entry_type      push_entry,
   input  wire logic                          pop,
   output bsfd_pkg::bsfd_entry_type           head_entry,
   output bsfd_pkg::bsfd_queue_stat_type      stat
);
   import bsfd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   bsfd_entry_type   slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;

   assign head_entry = slot_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == CNT_FULL);
   assign stat.empty = (count_ff == '0);

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_ONE;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_ONE;
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_ONE;
      end else if (pop && !push) begin
         count_in = count_ff - CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/bsfd_back.sv =====
// back end: runs the crc, captures fields and builds the result word
// depends on bsfd_pkg
`default_nettype none

module bsfd_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire bsfd_pkg::bsfd_entry_type  head_entry,
   input  wire bsfd_pkg::bsfd_queue_stat_type q_stat,
   output logic                           q_pop,
   output bsfd_pkg::bsfd_back_stat_type   stat,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output bsfd_pkg::bsfd_result_type      rsp_result
);
   import bsfd_pkg::*;

   logic [15:0] crc_ff,     crc_in;
   logic [7:0]  crc_low_ff, crc_low_in;
   logic [15:0] mode_ff,    mode_in;
   logic [31:0] volt_ff,    volt_in;
   logic [31:0] amp_ff,     amp_in;
   logic [15:0] temp_ff,    temp_in;
   logic [31:0] fault_ff,   fault_in;
   logic [15:0] level_ff,   level_in;
   logic [31:0] cap_ff,     cap_in;
   logic        valid_ff,   valid_in;
   bsfd_result_type result_ff, result_in;

   logic             is_final;
   logic             frame_start;
   logic [7:0]       b;
   logic [IDX_W-1:0] idx;
   logic [IDX_W-1:0] ofs_mode, ofs_volt, ofs_amp, ofs_temp, ofs_fault, ofs_level, ofs_cap;

   assign b           = head_entry.rx_byte;
   assign idx         = head_entry.idx;
   assign is_final    = (head_entry.op == OP_FINAL);
   assign frame_start = (idx == '0);

   // a final word waits for the output register to free up
   assign q_pop = !q_stat.empty && (!is_final || !valid_ff || rsp_ready);
   assign stat.pop       = q_pop;
   assign stat.final_pop = q_pop && is_final;

   // byte lanes relative to each field offset
   assign ofs_mode  = idx - OFS_MODE;
   assign ofs_volt  = idx - OFS_VOLT;
   assign ofs_amp   = idx - OFS_AMP;
   assign ofs_temp  = idx - OFS_TEMP;
   assign ofs_fault = idx - OFS_FAULT;
   assign ofs_level = idx - OFS_LEVEL;
   assign ofs_cap   = idx - OFS_CAP;

   // crc and field capture
   always_comb begin
      crc_in     = crc_ff;
      crc_low_in = crc_low_ff;
      mode_in    = mode_ff;
      volt_in    = volt_ff;
      amp_in     = amp_ff;
      temp_in    = temp_ff;
      fault_in   = fault_ff;
      level_in   = level_ff;
      cap_in     = cap_ff;
      if (q_pop) begin
         // a new frame restarts the crc and clears the captures
         if (frame_start) begin
            crc_in     = CRC_INIT;
            crc_low_in = '0;
            mode_in    = '0;
            volt_in    = '0;
            amp_in     = '0;
            temp_in    = '0;
            fault_in   = '0;
            level_in   = '0;
            cap_in     = '0;
         end
         case (head_entry.op)
            OP_DATA: begin
               crc_in = crc_update(crc_in, b);
               if (head_entry.cap_kind) begin
                  if (ofs_level < 6'd2) level_in[{ofs_level[0], 3'b000} +: 8] = b;
                  if (ofs_cap < 6'd4)   cap_in[{ofs_cap[1:0], 3'b000} +: 8] = b;
               end else begin
                  if (ofs_mode < 6'd2)  mode_in[{ofs_mode[0], 3'b000} +: 8] = b;
                  if (ofs_volt < 6'd4)  volt_in[{ofs_volt[1:0], 3'b000} +: 8] = b;
                  if (ofs_amp < 6'd4)   amp_in[{ofs_amp[1:0], 3'b000} +: 8] = b;
                  if (ofs_temp < 6'd2)  temp_in[{ofs_temp[0], 3'b000} +: 8] = b;
                  if (ofs_fault < 6'd4) fault_in[{ofs_fault[1:0], 3'b000} +: 8] = b;
               end
            end
            OP_CRC_LOW: begin
               crc_low_in = b;
            end
            default: begin
            end
         endcase
      end
   end

   // result word on the final byte of a frame
   always_comb begin
      result_in        = result_ff;
      valid_in         = valid_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (q_pop && is_final) begin
         valid_in                    = 1'b1;
         result_in                   = '0;
         result_in.crc_ok            = ({b, crc_low_ff} == crc_ff);
         if (head_entry.cap_kind) begin
            result_in.soc_centi_percent = level_ff;
            result_in.capacity_mah      = cap_ff;
         end else begin
            result_in.voltage_mv    = volt_ff;
            result_in.current_ma    = amp_ff;
            result_in.temperature_c = {1'b0, temp_ff} - TEMP_OFFSET;
            result_in.protect_flags = fault_ff;
            if (fault_ff == '0) begin
               result_in.health = HEALTH_GOOD;
            end else if ((fault_ff & OVERHEAT_MASK) != '0) begin
               result_in.health = HEALTH_OVERHEAT;
            end else begin
               result_in.health = HEALTH_FAILURE;
            end
            if (mode_ff == MODE_CHARGING) begin
               result_in.charge_status = CHG_CHARGING;
            end else if (mode_ff == MODE_DISCHARGING) begin
               result_in.charge_status = CHG_DISCHARGING;
            end else begin
               result_in.charge_status = CHG_OTHER;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      crc_ff     <= crc_in;
      crc_low_ff <= crc_low_in;
      mode_ff    <= mode_in;
      volt_ff    <= volt_in;
      amp_ff     <= amp_in;
      temp_ff    <= temp_in;
      fault_ff   <= fault_in;
      level_ff   <= level_in;
      cap_ff     <= cap_in;
      result_ff  <= result_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

`default_nettype wire

// ===== rtl/core/battery_status_frame_decoder.sv =====
// result path: the final byte is registered in a queue slot, then the result word in the output register
// throughput: one byte per cycle while the queue is not full; the crc step is one unrolled byte update per cycle
// the output register lets the queue keep filling while a result waits
// reset: synchronous; frame position to byte 0, queue and output emptied, block_kind to 0
// top level of the frame decoder; depends on bsfd_pkg, bsfd_front, bsfd_queue, bsfd_back and the defines header
`default_nettype none

`include "battery_status_frame_decoder_defines.svh"

module battery_status_frame_decoder #(
   parameter int QUEUE_DEPTH = bsfd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // byte stream in
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,  // [7:0] rx_byte
   input  wire logic                              req_tuser,  // [0] first_byte
   // result stream out
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [31:0] voltage_mv, [63:32] current_ma, [80:64] temperature_c,
   // [112:81] protect_flags, [114:113] health, [116:115] charge_status,
   // [132:117] soc_centi_percent, [164:133] capacity_mah, [167:165] zero
   output logic [bsfd_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                   rsp_tuser,  // [0] crc_ok
   // configuration
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [bsfd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [bsfd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bsfd_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);
   import bsfd_pkg::*;

   logic                block_kind_ff, block_kind_in;
   logic                csr_write;
   logic                q_push;
   logic                q_pop;
   bsfd_entry_type      q_in_entry;
   bsfd_entry_type      q_head_entry;
   bsfd_queue_stat_type q_stat;
   bsfd_back_stat_type  back_stat;
   bsfd_result_type     result;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      block_kind_in = block_kind_ff;
      if (csr_write && (csr_paddr[CSR_ADDR_W-1:2] == REG_BLOCK_KIND)) begin
         block_kind_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_kind_ff <= 1'b0;
      end else begin
         block_kind_ff <= block_kind_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_W-1:2] == REG_BLOCK_KIND) begin
         csr_prdata[0] = block_kind_ff;
      end
   end

   bsfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .block_kind (block_kind_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_stat     (q_stat),
      .q_push     (q_push),
      .q_entry    (q_in_entry)
   );

   bsfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in_entry),
      .pop        (q_pop),
      .head_entry (q_head_entry),
      .stat       (q_stat)
   );

   bsfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (q_head_entry),
      .q_stat     (q_stat),
      .q_pop      (q_pop),
      .stat       (back_stat),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   // result packing
   assign rsp_tuser = result.crc_ok;
   assign rsp_tdata = {3'b000,
                       result.capacity_mah,
                       result.soc_centi_percent,
                       result.charge_status,
                       result.health,
                       result.protect_flags,
                       result.temperature_c,
                       result.current_ma,
                       result.voltage_mv};

   // checks
   `BSFD_ASSERT_IMPLY(a_no_push_when_full, q_push, !q_stat.full)
   `BSFD_ASSERT_IMPLY(a_pop_needs_entry, back_stat.pop, !q_stat.empty)
   `BSFD_ASSERT_IMPLY(a_result_from_final, $rose(rsp_tvalid), $past(back_stat.final_pop))

endmodule

`default_nettype wire

// ===== tb/battery_status_frame_decoder_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the battery status frame decoder: byte stream in, decoded words out
// holds its own decoder model and compares every result word; depends on bsfd_pkg and the rtl top

module battery_status_frame_decoder_tb;
   import bsfd_pkg::*;

   localparam int ITEM_TARGET = 1350;
   localparam int IDLE_PCT    = 19;
   localparam int SETTLE_CYC  = 16;
   localparam logic [CSR_ADDR_W-1:0] KIND_ADDR = {REG_BLOCK_KIND, 2'b00};
   localparam logic KIND_STATUS   = 1'b0;
   localparam logic KIND_CAPACITY = 1'b1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata   = '0;  // [7:0] rx_byte
   logic                   req_tuser   = 1'b0; // [0] first_byte
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   // [31:0] voltage_mv, [63:32] current_ma, [80:64] temperature_c,
   // [112:81] protect_flags, [114:113] health, [116:115] charge_status,
   // [132:117] soc_centi_percent, [164:133] capacity_mah, [167:165] zero
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;          // [0] crc_ok
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // decoder model state
   logic        kind_reg = KIND_STATUS;
   logic [5:0]  frame_pos = '0;
   logic [15:0] crc_acc = CRC_INIT;
   logic [7:0]  crc_lo_rx = '0;
   logic [31:0] mode_w = '0, volt_w = '0, amp_w = '0, temp_w = '0;
   logic [31:0] fault_w = '0, level_w = '0, cap_w = '0;

   bsfd_result_type pending_results[$];
   logic [7:0]      frame_buf[$];
   int              mismatch_count = 0;
   int              bytes_sent = 0;
   bit              idle_on = 1'b1;

   battery_status_frame_decoder u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // reflected crc-16, one byte
   function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
   endfunction

   // little-endian byte placement into a captured field
   function automatic logic [31:0] put_le(input logic [31:0] acc, input int idx, input int base,
                                          input int n, input logic [7:0] b);
      if (idx >= base && idx < base + n) acc[8*(idx-base) +: 8] = b;
      return acc;
   endfunction

   // one accepted byte through the decoder model; returns 1 when a result word is due
   function automatic bit decode_byte(input logic [7:0] b, input logic first,
                                      output bsfd_result_type r);
      int last;
      int idx;
      r = '0;
      last = kind_reg ? 12 : 34;
      if (first) frame_pos = '0;
      idx = frame_pos;
      if (idx > last) return 1'b0;

      // byte 0 restarts crc and captures, flagged or not
      if (idx == 0) begin
         crc_acc = CRC_INIT;
         crc_lo_rx = '0;
         mode_w = '0; volt_w = '0; amp_w = '0; temp_w = '0;
         fault_w = '0; level_w = '0; cap_w = '0;
      end

      if (idx < last - 1) begin
         crc_acc = crc_step(crc_acc, b);
         if (kind_reg) begin
            level_w = put_le(level_w, idx, 3, 2, b);
            cap_w   = put_le(cap_w, idx, 7, 4, b);
         end else begin
            mode_w  = put_le(mode_w, idx, 3, 2, b);
            volt_w  = put_le(volt_w, idx, 5, 4, b);
            amp_w   = put_le(amp_w, idx, 9, 4, b);
            temp_w  = put_le(temp_w, idx, 17, 2, b);
            fault_w = put_le(fault_w, idx, 25, 4, b);
         end
         frame_pos = 6'(idx + 1);
         return 1'b0;
      end
      if (idx == last - 1) begin
         crc_lo_rx = b;
         frame_pos = 6'(idx + 1);
         return 1'b0;
      end

      // final byte: received crc is low byte first
      frame_pos = IDLE_COUNT;
      r.crc_ok = ({b, crc_lo_rx} == crc_acc);
      if (kind_reg) begin
         r.soc_centi_percent = level_w[15:0];
         r.capacity_mah      = cap_w;
      end else begin
         r.voltage_mv    = volt_w;
         r.current_ma    = amp_w;
         r.temperature_c = {1'b0, temp_w[15:0]} - 17'd40;
         r.protect_flags = fault_w;
         if (fault_w == '0)                         r.health = HEALTH_GOOD;
         else if ((fault_w & OVERHEAT_MASK) != '0) r.health = HEALTH_OVERHEAT;
         else                                        r.health = HEALTH_FAILURE;
         if (mode_w[15:0] == MODE_CHARGING)         r.charge_status = CHG_CHARGING;
         else if (mode_w[15:0] == MODE_DISCHARGING) r.charge_status = CHG_DISCHARGING;
         else                                        r.charge_status = CHG_OTHER;
      end
      return 1'b1;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch on %s: expected %h, got %h", name, want, got);
      end
   endtask

   // model every accepted byte
   always @(posedge clock) begin
      bsfd_result_type r;
      if (!reset && req_tvalid && req_tready) begin
         if (decode_byte(req_tdata, req_tuser, r)) pending_results.push_back(r);
      end
   end

   // compare every accepted result word with the oldest prediction
   always @(posedge clock) begin
      bsfd_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("result word with no prediction: %h", rsp_tdata);
         end else begin
            want = pending_results.pop_front();
            check_field("crc_ok", want.crc_ok, rsp_tuser);
            check_field("voltage_mv", want.voltage_mv, rsp_tdata[31:0]);
            check_field("current_ma", want.current_ma, rsp_tdata[63:32]);
            // compared as raw 17-bit patterns, no sign extension
            check_field("temperature_c", {15'b0, want.temperature_c}, rsp_tdata[80:64]);
            check_field("protect_flags", want.protect_flags, rsp_tdata[112:81]);
            check_field("health", want.health, rsp_tdata[114:113]);
            check_field("charge_status", want.charge_status, rsp_tdata[116:115]);
            check_field("soc_centi_percent", want.soc_centi_percent, rsp_tdata[132:117]);
            check_field("capacity_mah", want.capacity_mah, rsp_tdata[164:133]);
            check_field("pad", '0, rsp_tdata[167:165]);
         end
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_tready <= idle_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
   end

   // one byte word on req, with random gaps ahead of it
   task automatic send_byte(input logic [7:0] b, input logic first);
      while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // wait for every prediction to be met, then for the pipeline to empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // write block_kind, then read it back
   task automatic set_kind(input logic kind);
      settle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= KIND_ADDR;
      csr_pwdata  <= {31'b0, kind};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      kind_reg = kind;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_psel    <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      check_field("block_kind readback", {31'b0, kind_reg}, csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // frame body without the crc bytes
   task automatic fill_frame(input logic kind, input bit rand_fill, input logic [7:0] fill_val);
      frame_buf.delete();
      repeat (kind ? 11 : 33) frame_buf.push_back(rand_fill ? 8'($urandom) : fill_val);
   endtask

   task automatic poke_le(input int base, input int n, input logic [31:0] value);
      for (int i = 0; i < n; i++) frame_buf[base+i] = value[8*i +: 8];
   endtask

   // append crc low byte first; optionally flip one bit of it
   task automatic seal_frame(input bit bad_crc);
      logic [15:0] c;
      int pos;
      c = CRC_INIT;
      foreach (frame_buf[i]) c = crc_step(c, frame_buf[i]);
      frame_buf.push_back(c[7:0]);
      frame_buf.push_back(c[15:8]);
      if (bad_crc) begin
         pos = frame_buf.size() - 1 - $urandom_range(0, 1);
         frame_buf[pos] = frame_buf[pos] ^ 8'(1 << $urandom_range(0, 7));
      end
   endtask

   task automatic send_frame(input logic start_flag, input int first_idx, input int count);
      for (int i = first_idx; i < first_idx + count; i++)
         send_byte(frame_buf[i], start_flag && (i == 0));
   endtask

   // status fields biased toward the decode corners
   task automatic shape_status_fields();
      case ($urandom_range(0, 3))
         0: poke_le(3, 2, MODE_CHARGING);
         1: poke_le(3, 2, MODE_DISCHARGING);
         default: ;
      endcase
      case ($urandom_range(0, 4))
         0: poke_le(25, 4, 32'h0);
         1: poke_le(25, 4, 32'h8);
         2: poke_le(25, 4, 32'h10);
         3: poke_le(25, 4, $urandom & ~OVERHEAT_MASK);
         default: ;
      endcase
      if ($urandom_range(0, 1)) poke_le(17, 2, $urandom_range(0, 80));
   endtask

   // first bytes after reset with no start flag still form a frame
   task automatic test_unflagged_after_reset();
      fill_frame(KIND_STATUS, 1'b1, 8'h00);
      seal_frame(1'b0);
      send_frame(1'b0, 0, frame_buf.size());
   endtask

   // all-ones and all-zeros bodies for both kinds
   task automatic test_field_extremes();
      for (int k = 0; k < 2; k++) begin
         set_kind(k[0]);
         fill_frame(k[0], 1'b0, 8'hFF);
         seal_frame(1'b0);
         send_frame(1'b1, 0, frame_buf.size());
         fill_frame(k[0], 1'b0, 8'h00);
         seal_frame(1'b0);
         send_frame(1'b1, 0, frame_buf.size());
      end
      set_kind(KIND_STATUS);
   endtask

   // health and charge status decode, temperature around the offset
   task automatic test_status_decode();
      logic [15:0] modes[4]  = '{16'd1, 16'd2, 16'd3, 16'h0100};
      logic [31:0] faults[4] = '{32'h8, 32'h10, 32'h1, 32'h8000_0000};
      logic [15:0] temps[4]  = '{16'd39, 16'd40, 16'd41, 16'd0};
      for (int i = 0; i < 4; i++) begin
         fill_frame(KIND_STATUS, 1'b1, 8'h00);
         poke_le(3, 2, modes[i]);
         poke_le(25, 4, faults[i]);
         poke_le(17, 2, temps[i]);
         seal_frame(1'b0);
         send_frame(1'b1, 0, frame_buf.size());
      end
   endtask

   // corrupted crc, then a clean frame
   task automatic test_bad_crc();
      for (int i = 0; i < 2; i++) begin
         fill_frame(KIND_STATUS, 1'b1, 8'h00);
         seal_frame(i == 0);
         send_frame(1'b1, 0, frame_buf.size());
      end
   endtask

   // start flag cutting a frame short, and bytes trailing a finished frame
   task automatic test_frame_restart();
      fill_frame(KIND_STATUS, 1'b1, 8'h00);
      seal_frame(1'b0);
      send_frame(1'b1, 0, 20);
      fill_frame(KIND_STATUS, 1'b1, 8'h00);
      seal_frame(1'b0);
      send_frame(1'b1, 0, frame_buf.size());
      repeat (5) send_byte(8'($urandom), 1'b0);
      send_frame(1'b1, 0, frame_buf.size());
   endtask

   // block_kind changed inside a frame, before and past the new final byte
   task automatic test_kind_switch_mid_frame();
      fill_frame(KIND_CAPACITY, 1'b1, 8'h00);
      seal_frame(1'b0);
      send_frame(1'b1, 0, 6);
      set_kind(KIND_CAPACITY);
      send_frame(1'b0, 6, frame_buf.size() - 6);
      set_kind(KIND_STATUS);
      fill_frame(KIND_STATUS, 1'b1, 8'h00);
      seal_frame(1'b0);
      send_frame(1'b1, 0, 20);
      set_kind(KIND_CAPACITY);
      repeat (4) send_byte(8'($urandom), 1'b0);
      fill_frame(KIND_CAPACITY, 1'b1, 8'h00);
      seal_frame(1'b0);
      send_frame(1'b1, 0, frame_buf.size());
      set_kind(KIND_STATUS);
   endtask

   // phases of mostly well-formed frames with random content, plus broken ones and noise
   task automatic test_random_traffic();
      int phase;
      int pick;
      logic kind;
      phase = 0;
      while (bytes_sent < ITEM_TARGET) begin
         kind = (phase < 2) ? phase[0] : 1'($urandom_range(0, 1));
         set_kind(kind);
         idle_on = (phase != 3);
         repeat ($urandom_range(3, 8)) begin
            pick = $urandom_range(0, 99);
            fill_frame(kind, 1'b1, 8'h00);
            if (!kind) shape_status_fields();
            seal_frame(pick >= 70 && pick < 80);
            if (pick >= 80 && pick < 88) begin
               send_frame(1'b1, 0, $urandom_range(1, frame_buf.size() - 1));
            end else if (pick >= 94) begin
               repeat ($urandom_range(1, 12)) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
            end else begin
               send_frame(1'b1, 0, frame_buf.size());
               if (pick >= 88) repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'b0);
            end
         end
         phase++;
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_unflagged_after_reset();
      test_field_extremes();
      test_status_decode();
      test_bad_crc();
      test_frame_restart();
      test_kind_switch_mid_frame();
      test_random_traffic();
      settle();
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // hang guard
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
